[rtl/lrud_pkg.sv]
// Package for the LRU block cache directory: sizes, request codes,
// register map and request/result structs for lrud_dir and the top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lrud_pkg;

    // Directory geometry
    localparam int WAYS     = 8;
    localparam int TAG_BITS = 32;
    localparam int TAG_W    = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam int WAY_W    = $clog2(WAYS);
    localparam int AGE_W    = $clog2(WAYS);
    localparam int CNT_W    = $clog2(WAYS + 1);

    // Field widths of the channels
    localparam int KIND_W   = 2;
    localparam int BLOCK_W  = 32;
    localparam int OWAY_W   = 3;
    localparam int TOTAL_W  = 32;

    // Configuration port
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int CAP_W    = 4;
    localparam logic [0:0]       REG_WAYS_IN_USE = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET       = 4'd8;

    // Request codes
    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_MARK   = 2'd2
    } t_kind;

    // One request beat
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BLOCK_W-1:0] block_number;
        logic               insert_dirty;
    } t_req;

    // One result beat
    typedef struct packed {
        logic               hit;
        logic [OWAY_W-1:0]  way;
        logic               evicted;
        logic [BLOCK_W-1:0] evicted_block;
        logic               evicted_dirty;
        logic [TOTAL_W-1:0] hit_total;
        logic [TOTAL_W-1:0] miss_total;
    } t_res;

endpackage

`default_nettype wire

[rtl/lrud_cfg.sv]
// APB-style configuration register of the directory (ways_in_use).
// Depends on lrud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrud_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lrud_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lrud_pkg::DATA_W-1:0] pwdata,
    output logic      [lrud_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output logic      [lrud_pkg::CAP_W-1:0]  o_ways_in_use
);

    logic                       sel_ways_in_use;
    logic [lrud_pkg::CAP_W-1:0] r_cap;
    logic                       wr_en;

    // Register select on the word index of the byte address
    assign sel_ways_in_use = (paddr[lrud_pkg::ADDR_W-1:2] == lrud_pkg::REG_WAYS_IN_USE);
    assign pready          = 1'b1;
    assign wr_en           = psel && penable && pwrite && pready && sel_ways_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lrud_pkg::CAP_RESET;
        end else if (wr_en) begin
            r_cap <= pwdata[lrud_pkg::CAP_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (sel_ways_in_use) begin
            prdata = lrud_pkg::DATA_W'(r_cap);
        end
    end

    assign o_ways_in_use = r_cap;

endmodule

`default_nettype wire

[rtl/lrud_dir.sv]
// Tag directory: entry state, parallel tag compare, LRU ranks,
// victim / free-way selection and the saturating hit and miss counters.
// Depends on lrud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrud_dir (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    input  wire lrud_pkg::t_req             i_req,
    input  wire logic [lrud_pkg::CAP_W-1:0] i_cap,
    output lrud_pkg::t_res                  o_res
);

    localparam int WAYS  = lrud_pkg::WAYS;
    localparam int TAG_W = lrud_pkg::TAG_W;
    localparam int WAY_W = lrud_pkg::WAY_W;
    localparam int AGE_W = lrud_pkg::AGE_W;
    localparam int CNT_W = lrud_pkg::CNT_W;
    localparam int TOT_W = lrud_pkg::TOTAL_W;

    // Entry state
    logic [WAYS-1:0]             r_valid, n_valid;
    logic [WAYS-1:0]             r_dirty, n_dirty;
    logic [AGE_W-1:0]            r_age [WAYS];
    logic [AGE_W-1:0]            n_age [WAYS];
    logic [TAG_W-1:0]            r_tag [WAYS];
    logic [TOT_W-1:0]            r_hit_cnt, n_hit_cnt;
    logic [TOT_W-1:0]            r_miss_cnt, n_miss_cnt;

    // Decode results
    logic [TAG_W-1:0]            req_tag;
    logic                        hit_any;
    logic [WAY_W-1:0]            hit_way;
    logic                        vic_found;
    logic [WAY_W-1:0]            vic_way;
    logic [WAY_W-1:0]            free_way;
    logic [CNT_W-1:0]            used;
    logic [CNT_W-1:0]            cap;
    logic                        evict;
    logic [WAY_W-1:0]            slot;
    logic                        tag_we;
    logic [AGE_W-1:0]            touch_age [WAYS];

    assign req_tag = i_req.block_number[TAG_W-1:0];

    // Tag match (lowest way wins), free way, occupancy
    always_comb begin
        hit_any  = 1'b0;
        hit_way  = '0;
        free_way = '0;
        used     = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == req_tag)) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (!r_valid[i]) begin
                free_way = WAY_W'(i);
            end
        end
        for (int i = 0; i < WAYS; i++) begin
            used = used + CNT_W'(r_valid[i]);
        end
    end

    // Oldest valid entry, first one on a tie
    always_comb begin
        vic_found = 1'b0;
        vic_way   = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (r_valid[i] && (!vic_found || (r_age[i] > r_age[vic_way]))) begin
                vic_found = 1'b1;
                vic_way   = WAY_W'(i);
            end
        end
    end

    // Effective capacity: zero acts as one, clamp at the way count
    always_comb begin
        if (i_cap == '0) begin
            cap = CNT_W'(1);
        end else if (32'(i_cap) > 32'(WAYS)) begin
            cap = CNT_W'(WAYS);
        end else begin
            cap = CNT_W'(i_cap);
        end
    end

    assign evict = (used >= cap) && vic_found;
    assign slot  = evict ? vic_way : free_way;

    // Ranks after making the hit way most recent
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            touch_age[i] = r_age[i];
            if ((WAY_W'(i) != hit_way) && r_valid[i] && (r_age[i] < r_age[hit_way])) begin
                touch_age[i] = r_age[i] + AGE_W'(1);
            end
        end
        touch_age[hit_way] = '0;
    end

    // Next state and result
    always_comb begin
        n_valid    = r_valid;
        n_dirty    = r_dirty;
        n_age      = r_age;
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        tag_we     = 1'b0;
        o_res      = '0;
        case (lrud_pkg::t_kind'(i_req.kind))
            lrud_pkg::KIND_LOOKUP: begin
                if (hit_any) begin
                    o_res.hit = 1'b1;
                    o_res.way = lrud_pkg::OWAY_W'(hit_way);
                    n_age     = touch_age;
                    if (r_hit_cnt != '1) begin
                        n_hit_cnt = r_hit_cnt + TOT_W'(1);
                    end
                end else if (r_miss_cnt != '1) begin
                    n_miss_cnt = r_miss_cnt + TOT_W'(1);
                end
            end
            lrud_pkg::KIND_INSERT: begin
                if (hit_any) begin
                    // present block: update in place, way reads zero
                    o_res.hit        = 1'b1;
                    n_dirty[hit_way] = i_req.insert_dirty;
                    n_age            = touch_age;
                end else begin
                    if (evict) begin
                        o_res.evicted       = 1'b1;
                        o_res.evicted_block = lrud_pkg::BLOCK_W'(r_tag[vic_way]);
                        o_res.evicted_dirty = r_dirty[vic_way];
                    end
                    for (int i = 0; i < WAYS; i++) begin
                        if (r_valid[i] && (WAY_W'(i) != slot)) begin
                            n_age[i] = r_age[i] + AGE_W'(1);
                        end
                    end
                    n_valid[slot] = 1'b1;
                    n_dirty[slot] = i_req.insert_dirty;
                    n_age[slot]   = '0;
                    tag_we        = 1'b1;
                    o_res.way     = lrud_pkg::OWAY_W'(slot);
                end
            end
            lrud_pkg::KIND_MARK: begin
                if (hit_any) begin
                    o_res.hit        = 1'b1;
                    o_res.way        = lrud_pkg::OWAY_W'(hit_way);
                    n_dirty[hit_way] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_res.hit_total  = n_hit_cnt;
        o_res.miss_total = n_miss_cnt;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_dirty    <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            for (int i = 0; i < WAYS; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_req_valid) begin
            r_valid    <= n_valid;
            r_dirty    <= n_dirty;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
            r_age      <= n_age;
        end
    end

    // Tags: no reset, only read while the entry is valid
    always_ff @(posedge i_clk) begin
        if (i_req_valid && tag_we) begin
            r_tag[slot] <= req_tag;
        end
    end

    // Checks
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_res.evicted) |-> (used >= cap))
        else $error("eviction below capacity");
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_res.hit && o_res.evicted))
        else $error("hit and eviction together");
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && tag_we) |=> r_valid[$past(slot)])
        else $error("filled way not valid");
    a_hit_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_hit_cnt >= $past(r_hit_cnt)))
        else $error("hit counter went down");
    a_used_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && tag_we && !evict) |-> (used < cap))
        else $error("fill without room");

endmodule

`default_nettype wire

[rtl/lru_block_cache_directory.sv]
// Top level of the LRU block cache directory: request register, directory,
// result register and configuration port.
// Depends on lrud_pkg, lrud_cfg, lrud_dir.
//
//   channel  direction  handshake                 payload
//   request  in         i_in_valid / o_in_stall   i_kind, i_block_number, i_insert_dirty
//   result   out        o_out_valid / i_out_stall o_hit .. o_miss_total
//   config   in         psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// One request per cycle while the result side does not stall; the request beat lands
// in the request register, and the tag compare and update then load the result
// register, from which the result beat is presented.
// The rate is set by the combinational parallel compare over all ways.
// Reset is synchronous and active low; there is no clearing pass.
// A stalled result holds the result register; the request register then holds
// and the request side stalls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module lru_block_cache_directory (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [lrud_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [lrud_pkg::BLOCK_W-1:0]  i_block_number,
    input  wire logic                          i_insert_dirty,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_hit,
    output logic      [lrud_pkg::OWAY_W-1:0]   o_way,
    output logic                               o_evicted,
    output logic      [lrud_pkg::BLOCK_W-1:0]  o_evicted_block,
    output logic                               o_evicted_dirty,
    output logic      [lrud_pkg::TOTAL_W-1:0]  o_hit_total,
    output logic      [lrud_pkg::TOTAL_W-1:0]  o_miss_total,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lrud_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lrud_pkg::DATA_W-1:0]   pwdata,
    output logic      [lrud_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    logic                       r_in_valid;
    lrud_pkg::t_req             r_req;
    logic                       r_out_valid;
    lrud_pkg::t_res             r_res;
    lrud_pkg::t_res             dir_res;
    logic [lrud_pkg::CAP_W-1:0] cap;
    logic                       in_acc;
    logic                       proc;

    // Handshake: the request register advances when the result register is free
    assign proc       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req.kind         <= i_kind;
            r_req.block_number <= i_block_number;
            r_req.insert_dirty <= i_insert_dirty;
        end
        if (proc) begin
            r_res <= dir_res;
        end
    end

    lrud_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_ways_in_use (cap)
    );

    lrud_dir u_dir (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (proc),
        .i_req       (r_req),
        .i_cap       (cap),
        .o_res       (dir_res)
    );

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_res.hit;
    assign o_way           = r_res.way;
    assign o_evicted       = r_res.evicted;
    assign o_evicted_block = r_res.evicted_block;
    assign o_evicted_dirty = r_res.evicted_dirty;
    assign o_hit_total     = r_res.hit_total;
    assign o_miss_total    = r_res.miss_total;

endmodule

`default_nettype wire

[bench/lru_block_cache_directory_test.sv]
// Self-checking bench for the LRU block cache directory: directed and random
// lookup/insert/mark requests, scored against an in-bench recency model.
// Depends on lrud_pkg and lru_block_cache_directory.
`timescale 1ns / 1ps

module lru_block_cache_directory_test;
    import lrud_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_IDLE     = 5;
    localparam int HOLD_AT_BEAT = 250;
    localparam int HOLD_CYCLES  = 60;
    localparam int POOL_SIZE    = 12;
    localparam int PHASES       = 7;
    localparam logic [KIND_W-1:0] KIND_SPARE       = 2'd3;
    localparam logic [ADDR_W-1:0] WAYS_IN_USE_ADDR = ADDR_W'(4 * REG_WAYS_IN_USE);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request side
    logic              in_valid = 1'b0;
    t_req              in_beat  = '0;
    wire logic         in_stall;

    // result side
    logic              out_stall = 1'b0;
    wire logic         out_valid;
    wire logic         hit;
    wire logic [OWAY_W-1:0]  way;
    wire logic         evicted;
    wire logic [BLOCK_W-1:0] evicted_block;
    wire logic         evicted_dirty;
    wire logic [TOTAL_W-1:0] hit_total;
    wire logic [TOTAL_W-1:0] miss_total;

    // register port
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    wire logic [DATA_W-1:0] prdata;
    wire logic         pready;

    t_req pending_reqs[$];
    t_res expected_results[$];

    int error_count = 0;
    int beats_seen  = 0;
    int cycle_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    bit idle_on     = 1'b1;

    // directory mirror
    logic               dir_valid[WAYS];
    logic [BLOCK_W-1:0] dir_tag[WAYS];
    logic               dir_dirty[WAYS];
    int unsigned        dir_age[WAYS];
    logic [TOTAL_W-1:0] hit_count;
    logic [TOTAL_W-1:0] miss_count;
    logic [CAP_W-1:0]   cap_reg;

    logic [BLOCK_W-1:0] block_pool[POOL_SIZE];

    lru_block_cache_directory u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (in_beat.kind),
        .i_block_number (in_beat.block_number),
        .i_insert_dirty (in_beat.insert_dirty),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_hit          (hit),
        .o_way          (way),
        .o_evicted      (evicted),
        .o_evicted_block(evicted_block),
        .o_evicted_dirty(evicted_dirty),
        .o_hit_total    (hit_total),
        .o_miss_total   (miss_total),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the handshake hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Move way w to the front; valid entries that were younger age by one
    function automatic void promote_way(int w);
        for (int i = 0; i < WAYS; i++) begin
            if (i != w && dir_valid[i] && dir_age[i] < dir_age[w])
                dir_age[i]++;
        end
        dir_age[w] = 0;
    endfunction

    // Apply one request to the mirror and return the result beat it should produce
    function automatic t_res directory_step(t_req r);
        t_res res;
        int   found;
        int   victim;
        int   slot;
        int   used;
        int   cap;
        res    = '0;
        found  = -1;
        victim = -1;
        slot   = -1;
        used   = 0;
        for (int i = 0; i < WAYS; i++) begin
            if (dir_valid[i] && dir_tag[i] == r.block_number && found < 0)
                found = i;
            if (dir_valid[i])
                used++;
        end
        // out-of-range capacity clamps to 1..WAYS
        cap = (cap_reg == 0) ? 1 : (cap_reg > WAYS) ? WAYS : int'(cap_reg);

        case (r.kind)
            KIND_LOOKUP: begin
                if (found >= 0) begin
                    res.hit = 1'b1;
                    res.way = OWAY_W'(found);
                    promote_way(found);
                    if (hit_count != '1)
                        hit_count++;
                end else if (miss_count != '1) begin
                    miss_count++;
                end
            end
            KIND_INSERT: begin
                if (found >= 0) begin
                    // present block: refresh in place, way stays zero
                    res.hit = 1'b1;
                    dir_dirty[found] = r.insert_dirty;
                    promote_way(found);
                end else begin
                    if (used >= cap) begin
                        for (int i = 0; i < WAYS; i++) begin
                            if (dir_valid[i] && (victim < 0 || dir_age[i] > dir_age[victim]))
                                victim = i;
                        end
                        res.evicted       = 1'b1;
                        res.evicted_block = dir_tag[victim];
                        res.evicted_dirty = dir_dirty[victim];
                        dir_valid[victim] = 1'b0;
                        slot = victim;
                    end else begin
                        for (int i = 0; i < WAYS; i++) begin
                            if (!dir_valid[i] && slot < 0)
                                slot = i;
                        end
                    end
                    for (int i = 0; i < WAYS; i++) begin
                        if (dir_valid[i])
                            dir_age[i]++;
                    end
                    dir_valid[slot] = 1'b1;
                    dir_tag[slot]   = r.block_number;
                    dir_dirty[slot] = r.insert_dirty;
                    dir_age[slot]   = 0;
                    res.way = OWAY_W'(slot);
                end
            end
            KIND_MARK: begin
                if (found >= 0) begin
                    res.hit = 1'b1;
                    res.way = OWAY_W'(found);
                    dir_dirty[found] = 1'b1;
                end
            end
            default: begin
            end
        endcase

        res.hit_total  = hit_count;
        res.miss_total = miss_count;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Request driver: one beat per handshake, random gap after each accepted beat
    always @(posedge clk) begin : request_driver
        int gap;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (in_valid && !in_stall) begin
            expected_results.push_back(directory_step(in_beat));
            gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap == 0 && pending_reqs.size() != 0) begin
                in_beat <= pending_reqs.pop_front();
            end else begin
                in_valid <= 1'b0;
                gap_left <= gap;
            end
        end else if (!in_valid) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
                in_beat  <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // Result monitor: score each beat, then stall for a random number of cycles
    always @(posedge clk) begin : result_monitor
        t_res want;
        int   pause;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(hit));
                check_field("way", 32'(want.way), 32'(way));
                check_field("evicted", 32'(want.evicted), 32'(evicted));
                check_field("evicted_block", want.evicted_block, evicted_block);
                check_field("evicted_dirty", 32'(want.evicted_dirty), 32'(evicted_dirty));
                check_field("hit_total", want.hit_total, hit_total);
                check_field("miss_total", want.miss_total, miss_total);
            end
            beats_seen++;
            pause = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            // one long back-pressure stretch so the request side fills and stalls
            if (beats_seen == HOLD_AT_BEAT)
                pause = HOLD_CYCLES;
            stall_left <= pause;
            out_stall  <= (pause != 0);
        end else begin
            if (stall_left != 0)
                stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
    end

    task automatic queue_req(logic [KIND_W-1:0] kind, logic [BLOCK_W-1:0] blk, logic dirty);
        t_req r;
        r.kind         = kind;
        r.block_number = blk;
        r.insert_dirty = dirty;
        pending_reqs.push_back(r);
    endtask

    // Random requests, mostly on a small block pool so hits and evictions are common
    task automatic queue_random(int count);
        int                 pick;
        logic [KIND_W-1:0]  kind;
        logic [BLOCK_W-1:0] blk;
        foreach (block_pool[i]) begin
            if ($urandom_range(0, 1))
                block_pool[i] = $urandom;
        end
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                kind = KIND_LOOKUP;
            else if (pick < 80)
                kind = KIND_INSERT;
            else if (pick < 95)
                kind = KIND_MARK;
            else
                kind = KIND_SPARE;
            blk = ($urandom_range(0, 6) == 0) ? $urandom
                                              : block_pool[$urandom_range(0, POOL_SIZE - 1)];
            queue_req(kind, blk, 1'($urandom_range(0, 1)));
        end
    endtask

    // Wait until every request went out and every result came back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Write ways_in_use, then read it back
    task automatic write_ways_in_use(logic [CAP_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WAYS_IN_USE_ADDR;
        pwdata  <= {(DATA_W - CAP_W)'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cap_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[CAP_W-1:0] !== value) begin
            $error("ways_in_use: expected 0x%0h, got 0x%0h", value, prdata[CAP_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        int phase_cap[PHASES]   = '{0, 15, 1, 0, 8, 4, 8};
        int phase_items[PHASES] = '{60, 130, 110, 160, 160, 120, 120};
        bit phase_idle[PHASES]  = '{1, 1, 1, 1, 0, 1, 1};
        foreach (dir_valid[i]) begin
            dir_valid[i] = 1'b0;
            dir_tag[i]   = '0;
            dir_dirty[i] = 1'b0;
            dir_age[i]   = 0;
        end
        hit_count  = '0;
        miss_count = '0;
        cap_reg    = CAP_RESET;
        foreach (block_pool[i])
            block_pool[i] = $urandom;
        phase_cap[3] = $urandom_range(2, 7);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty misses, extreme block numbers, in-place insert, spare kind
        queue_req(KIND_LOOKUP, 32'h0000_0000, 1'b0);
        queue_req(KIND_MARK,   32'h0000_0000, 1'b0);
        queue_req(KIND_INSERT, 32'h0000_0000, 1'b0);
        queue_req(KIND_INSERT, 32'hFFFF_FFFF, 1'b1);
        queue_req(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        queue_req(KIND_MARK,   32'h0000_0000, 1'b1);
        queue_req(KIND_INSERT, 32'h0000_0000, 1'b0);
        queue_req(KIND_SPARE,  32'h0000_0000, 1'b1);
        queue_req(KIND_LOOKUP, 32'h0000_1234, 1'b0);
        // fill to the reset capacity, then one more insert evicts
        for (int i = 0; i < 6; i++)
            queue_req(KIND_INSERT, 32'h10 + i, i[0]);
        queue_req(KIND_INSERT, 32'h16, 1'b1);
        queue_req(KIND_LOOKUP, 32'hFFFF_FFFF, 1'b0);
        queue_req(KIND_MARK,   32'hFFFF_FFFF, 1'b0);
        queue_req(KIND_LOOKUP, 32'hA5A5_5A5A, 1'b0);
        wait_idle();

        // Random phases across capacity settings, extremes included
        for (int p = 0; p < PHASES; p++) begin
            write_ways_in_use(CAP_W'(phase_cap[p]));
            idle_on = phase_idle[p];
            if (p == 0) begin
                // capacity far below occupancy: each insert evicts exactly one
                queue_req(KIND_INSERT, 32'h20, 1'b1);
                queue_req(KIND_INSERT, 32'h21, 1'b0);
                queue_req(KIND_INSERT, 32'h22, 1'b1);
                queue_req(KIND_LOOKUP, 32'h22, 1'b0);
                queue_req(KIND_LOOKUP, 32'h21, 1'b0);
            end
            queue_random(phase_items[p]);
            wait_idle();
        end

        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
